>>> hw/rtl/dgnm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dgnm_pkg
// shared beat types, register indexes and fixed-point constants of the
// depth gradient normal matte
// ----------------------------------------------------------------------------
package dgnm_pkg;

    typedef struct packed {
        logic signed [31:0] depth_left;
        logic signed [31:0] depth_right;
        logic signed [31:0] depth_below;
        logic signed [31:0] depth_above;
        logic [15:0]        red_in;
        logic [15:0]        green_in;
        logic [15:0]        blue_in;
        logic [15:0]        alpha_in;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] red_out;
        logic [15:0] green_out;
        logic [15:0] blue_out;
        logic [15:0] alpha_out;
        logic [16:0] matte_value;
    } t_out_beat;

    typedef struct packed {
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        logic [15:0] a;
    } t_rgba;

    // stage control shared by the pipelined arithmetic units
    typedef struct packed {
        logic en;
        logic vld;
    } t_pipe_ctl;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIR_X     = 3'd0,
        CFG_DIR_Y     = 3'd1,
        CFG_DIR_Z     = 3'd2,
        CFG_TOLERANCE = 3'd3,
        CFG_SOFTNESS  = 3'd4,
        CFG_GAIN      = 3'd5,
        CFG_INVERT    = 3'd6
    } t_cfg_idx;

    localparam logic signed [15:0] RST_DIR_X     = 16'sd0;
    localparam logic signed [15:0] RST_DIR_Y     = 16'sd16384;
    localparam logic signed [15:0] RST_DIR_Z     = 16'sd0;
    localparam logic [16:0]        RST_TOLERANCE = 17'd32768;
    localparam logic [16:0]        RST_SOFTNESS  = 17'd13107;
    localparam logic [15:0]        RST_GAIN      = 16'd256;

    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [48:0] GRAD_RND  = 49'd256;
    localparam logic [40:0] GRAD_SAT  = 41'd1073741824;
    localparam logic [63:0] NORM_Z2   = 64'h0000_0001_0000_0000;
    localparam logic [17:0] SMOOTH_3  = 18'd196608;
    localparam logic [49:0] SMOOTH_RND = 50'h0_0000_8000_0000;
    localparam logic [32:0] CH_RND    = 33'd32768;

endpackage
`default_nettype wire

>>> hw/rtl/depth_gradient_normal_matte.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// depth_gradient_normal_matte
// per-sample surface normal from neighbour depths, smoothstep matte against
// a target direction, rgba scaled by the matte
// ----------------------------------------------------------------------------
// channel  | direction | handshake                 | beat
// ---------+-----------+---------------------------+---------------------------
// in       | sink      | i_in_valid / o_in_stall   | t_in_beat, four depths+rgba
// out      | source    | o_out_valid / i_out_stall | t_out_beat, rgba + matte
// cfg      | sink      | i_cfg_we, no back-pressure| index i_cfg_idx, i_cfg_wdata
//
// one beat per cycle sustained while the output is not stalled; stages in
// order: 5 front stages, 32-step normal-length root, 32-step and 18-step
// dividers for the cosine, 2 window stages, 16-step divider for the
// smoothstep ramp, 4 back stages incl. the output register
// a stalled output freezes every data stage, so nothing is lost or repeated;
// the input is held off only while the output register is full and stalled
// synchronous active-low reset clears valid bits and loads register defaults
// the direction length comes from a free-running 32-step root fed by the
// registers; it settles after reset and after a register write
// ----------------------------------------------------------------------------
module depth_gradient_normal_matte (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire dgnm_pkg::t_in_beat                  i_in_data,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output dgnm_pkg::t_out_beat                      o_out_data,
    input  wire logic                                i_cfg_we,
    input  wire logic [dgnm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [dgnm_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import dgnm_pkg::*;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic signed [15:0] r_dir_x;
    logic signed [15:0] r_dir_y;
    logic signed [15:0] r_dir_z;
    logic [16:0]        r_tol;
    logic [16:0]        r_soft;
    logic [15:0]        r_gain;
    logic               r_invert;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_x  <= RST_DIR_X;
            r_dir_y  <= RST_DIR_Y;
            r_dir_z  <= RST_DIR_Z;
            r_tol    <= RST_TOLERANCE;
            r_soft   <= RST_SOFTNESS;
            r_gain   <= RST_GAIN;
            r_invert <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DIR_X:     r_dir_x  <= i_cfg_wdata[15:0];
                CFG_DIR_Y:     r_dir_y  <= i_cfg_wdata[15:0];
                CFG_DIR_Z:     r_dir_z  <= i_cfg_wdata[15:0];
                CFG_TOLERANCE: r_tol    <= i_cfg_wdata;
                CFG_SOFTNESS:  r_soft   <= i_cfg_wdata;
                CFG_GAIN:      r_gain   <= i_cfg_wdata[15:0];
                CFG_INVERT:    r_invert <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // global stage enable: everything moves unless a finished beat waits
    // ------------------------------------------------------------------
    logic r_out_vld;
    logic w_en;

    assign w_en       = !(r_out_vld && i_out_stall);
    assign o_in_stall = !w_en;

    // ------------------------------------------------------------------
    // direction length, free-running from the registers
    // ------------------------------------------------------------------
    logic [30:0] r_dsq_x;
    logic [30:0] r_dsq_y;
    logic [30:0] r_dsq_z;
    logic [31:0] r_d2;
    logic [31:0] w_dl;
    logic        w_dl_vld;
    logic        w_dl_nz;
    logic        w_dir_nz;
    t_pipe_ctl   w_ctl_dl;

    always_ff @(posedge i_clk) begin
        r_dsq_x <= 31'(r_dir_x * r_dir_x);
        r_dsq_y <= 31'(r_dir_y * r_dir_y);
        r_dsq_z <= 31'(r_dir_z * r_dir_z);
        r_d2    <= 32'(r_dsq_x) + 32'(r_dsq_y) + 32'(r_dsq_z);
    end

    assign w_ctl_dl.en  = 1'b1;
    assign w_ctl_dl.vld = 1'b1;

    // sqrt(|d|^2 * 2^32): |d| in Q.16
    dgnm_isqrt #(
        .IN_W (64),
        .SB_W (1)
    ) u_dir_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_dl),
        .i_rad   ({r_d2, 32'd0}),
        .i_sb    (r_d2 != 32'd0),
        .o_vld   (w_dl_vld),
        .o_root  (w_dl),
        .o_sb    (w_dl_nz)
    );

    assign w_dir_nz = w_dl_vld && w_dl_nz;

    // ------------------------------------------------------------------
    // stage 1: central differences
    // ------------------------------------------------------------------
    logic               r_s1_vld;
    logic signed [32:0] r_s1_dx;
    logic signed [32:0] r_s1_dy;
    t_rgba              r_s1_rgba;
    t_rgba              w_in_rgba;

    assign w_in_rgba.r = i_in_data.red_in;
    assign w_in_rgba.g = i_in_data.green_in;
    assign w_in_rgba.b = i_in_data.blue_in;
    assign w_in_rgba.a = i_in_data.alpha_in;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_dx   <= 33'(i_in_data.depth_right) - 33'(i_in_data.depth_left);
            r_s1_dy   <= 33'(i_in_data.depth_above) - 33'(i_in_data.depth_below);
            r_s1_rgba <= w_in_rgba;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: gain (Q8.8), result in units of 2^-25
    // ------------------------------------------------------------------
    logic               r_s2_vld;
    logic signed [49:0] r_s2_gx;
    logic signed [49:0] r_s2_gy;
    t_rgba              r_s2_rgba;
    logic signed [16:0] w_gain_s;

    assign w_gain_s = $signed({1'b0, r_gain});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_gx   <= r_s1_dx * w_gain_s;
            r_s2_gy   <= r_s1_dy * w_gain_s;
            r_s2_rgba <= r_s1_rgba;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: round magnitude to Q.16, saturate at 2^30
    // ------------------------------------------------------------------
    function automatic logic signed [31:0] grad_q16(input logic signed [49:0] g);
        logic [48:0] mag;
        logic [40:0] rq;
        logic [30:0] sat;
        mag = g[49] ? 49'(-g) : g[48:0];
        rq  = 41'((mag + GRAD_RND) >> 9);
        sat = (rq > GRAD_SAT) ? GRAD_SAT[30:0] : rq[30:0];
        return g[49] ? -$signed({1'b0, sat}) : $signed({1'b0, sat});
    endfunction

    logic               r_s3_vld;
    logic signed [31:0] r_s3_gx;
    logic signed [31:0] r_s3_gy;
    t_rgba              r_s3_rgba;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_gx   <= grad_q16(r_s2_gx);
            r_s3_gy   <= grad_q16(r_s2_gy);
            r_s3_rgba <= r_s2_rgba;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: squares for the normal length, products for the dot
    // ------------------------------------------------------------------
    logic               r_s4_vld;
    logic [61:0]        r_s4_sqx;
    logic [61:0]        r_s4_sqy;
    logic signed [47:0] r_s4_pxd;
    logic signed [47:0] r_s4_pyd;
    t_rgba              r_s4_rgba;
    logic [30:0]        w_ax;
    logic [30:0]        w_ay;

    assign w_ax = r_s3_gx[31] ? 31'(-r_s3_gx) : r_s3_gx[30:0];
    assign w_ay = r_s3_gy[31] ? 31'(-r_s3_gy) : r_s3_gy[30:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_sqx  <= w_ax * w_ax;
            r_s4_sqy  <= w_ay * w_ay;
            r_s4_pxd  <= r_s3_gx * r_dir_x;
            r_s4_pyd  <= r_s3_gy * r_dir_y;
            r_s4_rgba <= r_s3_rgba;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: |n|^2 with the unit z term, dot numerator sign and magnitude
    // ------------------------------------------------------------------
    logic               r_s5_vld;
    logic [63:0]        r_s5_n2;
    logic               r_s5_neg;
    logic [46:0]        r_s5_u;
    t_rgba              r_s5_rgba;
    logic signed [48:0] w_num;

    assign w_num = -49'(r_s4_pxd) - 49'(r_s4_pyd) + (49'(r_dir_z) <<< 16);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5_n2   <= 64'(r_s4_sqx) + 64'(r_s4_sqy) + NORM_Z2;
            r_s5_neg  <= w_num[48];
            r_s5_u    <= w_num[48] ? 47'(-w_num) : w_num[46:0];
            r_s5_rgba <= r_s4_rgba;
        end
    end

    // ------------------------------------------------------------------
    // normal length
    // ------------------------------------------------------------------
    t_pipe_ctl   w_ctl_nl;
    logic        w_nl_vld;
    logic [31:0] w_nl;
    logic        w_nl_neg;
    logic [46:0] w_nl_u;
    t_rgba       w_nl_rgba;

    assign w_ctl_nl.en  = w_en;
    assign w_ctl_nl.vld = r_s5_vld;

    dgnm_isqrt #(
        .IN_W (64),
        .SB_W (112)
    ) u_norm_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_nl),
        .i_rad   (r_s5_n2),
        .i_sb    ({r_s5_neg, r_s5_u, r_s5_rgba}),
        .o_vld   (w_nl_vld),
        .o_root  (w_nl),
        .o_sb    ({w_nl_neg, w_nl_u, w_nl_rgba})
    );

    // ------------------------------------------------------------------
    // cosine: |num| * 2^16 / |n|, then * 2^16 / |d|
    // ------------------------------------------------------------------
    t_pipe_ctl   w_ctl_q1;
    logic        w_q1_vld;
    logic [31:0] w_q1;
    logic        w_q1_neg;
    t_rgba       w_q1_rgba;

    assign w_ctl_q1.en  = w_en;
    assign w_ctl_q1.vld = w_nl_vld;

    dgnm_div #(
        .NUM_W (63),
        .DEN_W (32),
        .QUO_W (32),
        .SB_W  (65)
    ) u_div_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_q1),
        .i_num   ({w_nl_u, 16'd0}),
        .i_den   (w_nl),
        .i_sb    ({w_nl_neg, w_nl_rgba}),
        .o_vld   (w_q1_vld),
        .o_quo   (w_q1),
        .o_sb    ({w_q1_neg, w_q1_rgba})
    );

    t_pipe_ctl   w_ctl_q2;
    logic        w_q2_vld;
    logic [17:0] w_q2;
    logic        w_q2_neg;
    t_rgba       w_q2_rgba;

    assign w_ctl_q2.en  = w_en;
    assign w_ctl_q2.vld = w_q1_vld;

    dgnm_div #(
        .NUM_W (48),
        .DEN_W (32),
        .QUO_W (18),
        .SB_W  (65)
    ) u_div_dir (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_q2),
        .i_num   ({w_q1, 16'd0}),
        .i_den   (w_dl),
        .i_sb    ({w_q1_neg, w_q1_rgba}),
        .o_vld   (w_q2_vld),
        .o_quo   (w_q2),
        .o_sb    ({w_q2_neg, w_q2_rgba})
    );

    // ------------------------------------------------------------------
    // stage 6: saturate and sign the cosine, zero for a zero direction
    // ------------------------------------------------------------------
    logic               r_s6_vld;
    logic signed [17:0] r_s6_dot;
    t_rgba              r_s6_rgba;
    logic [16:0]        w_cos;
    logic signed [17:0] w_dot;

    assign w_cos = (w_q2 > 18'(ONE_Q16)) ? ONE_Q16 : w_q2[16:0];

    always_comb begin
        if (!w_dir_nz) begin
            w_dot = '0;
        end else if (w_q2_neg) begin
            w_dot = -$signed({1'b0, w_cos});
        end else begin
            w_dot = $signed({1'b0, w_cos});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s6_dot  <= w_dot;
            r_s6_rgba <= w_q2_rgba;
        end
    end

    // ------------------------------------------------------------------
    // stage 7: compare against the window [lo, thr], ramp numerator
    // ------------------------------------------------------------------
    logic               r_s7_vld;
    logic               r_s7_le_lo;
    logic               r_s7_ge_thr;
    logic               r_s7_ge_lo;
    logic [32:0]        r_s7_num;
    t_rgba              r_s7_rgba;
    logic signed [19:0] w_thr;
    logic signed [19:0] w_lo;
    logic signed [19:0] w_dot20;
    logic signed [19:0] w_diff;

    assign w_thr   = $signed(20'(ONE_Q16)) - $signed({3'd0, r_tol});
    assign w_lo    = w_thr - $signed({3'd0, r_soft});
    assign w_dot20 = 20'(r_s6_dot);
    assign w_diff  = w_dot20 - w_lo;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s7_le_lo  <= w_dot20 <= w_lo;
            r_s7_ge_thr <= w_dot20 >= w_thr;
            r_s7_ge_lo  <= w_dot20 >= w_lo;
            r_s7_num    <= {w_diff[16:0], 16'd0};
            r_s7_rgba   <= r_s6_rgba;
        end
    end

    // ------------------------------------------------------------------
    // ramp position inside the window
    // ------------------------------------------------------------------
    t_pipe_ctl   w_ctl_t;
    logic        w_t_vld;
    logic [15:0] w_tq;
    logic        w_t_le_lo;
    logic        w_t_ge_thr;
    logic        w_t_ge_lo;
    t_rgba       w_t_rgba;

    assign w_ctl_t.en  = w_en;
    assign w_ctl_t.vld = r_s7_vld;

    dgnm_div #(
        .NUM_W (33),
        .DEN_W (17),
        .QUO_W (16),
        .SB_W  (67)
    ) u_div_ramp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_t),
        .i_num   (r_s7_num),
        .i_den   (r_soft),
        .i_sb    ({r_s7_le_lo, r_s7_ge_thr, r_s7_ge_lo, r_s7_rgba}),
        .o_vld   (w_t_vld),
        .o_quo   (w_tq),
        .o_sb    ({w_t_le_lo, w_t_ge_thr, w_t_ge_lo, w_t_rgba})
    );

    // ------------------------------------------------------------------
    // stage 8: clamp t, square it
    // ------------------------------------------------------------------
    logic        r_s8_vld;
    logic [16:0] r_s8_t;
    logic [32:0] r_s8_tsq;
    logic        r_s8_ge_lo;
    t_rgba       r_s8_rgba;
    logic [16:0] w_t;

    always_comb begin
        if (w_t_le_lo) begin
            w_t = '0;
        end else if (w_t_ge_thr) begin
            w_t = ONE_Q16;
        end else begin
            w_t = {1'b0, w_tq};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s8_t     <= w_t;
            r_s8_tsq   <= 33'(w_t) * 33'(w_t);
            r_s8_ge_lo <= w_t_ge_lo;
            r_s8_rgba  <= w_t_rgba;
        end
    end

    // ------------------------------------------------------------------
    // stage 9: smoothstep product t^2 * (3 - 2t)
    // ------------------------------------------------------------------
    logic        r_s9_vld;
    logic [48:0] r_s9_p;
    logic        r_s9_ge_lo;
    t_rgba       r_s9_rgba;
    logic [17:0] w_k;
    logic [50:0] w_p;

    assign w_k = SMOOTH_3 - {r_s8_t, 1'b0};
    assign w_p = r_s8_tsq * w_k;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s9_p     <= w_p[48:0];
            r_s9_ge_lo <= r_s8_ge_lo;
            r_s9_rgba  <= r_s8_rgba;
        end
    end

    // ------------------------------------------------------------------
    // stage 10: round to Q1.16, hard step on zero softness, invert
    // ------------------------------------------------------------------
    logic        r_s10_vld;
    logic [16:0] r_s10_matte;
    t_rgba       r_s10_rgba;
    logic [49:0] w_psum;
    logic [16:0] w_matte_raw;
    logic [16:0] w_matte;

    assign w_psum = 50'(r_s9_p) + SMOOTH_RND;

    always_comb begin
        if (r_soft == 17'd0) begin
            w_matte_raw = r_s9_ge_lo ? ONE_Q16 : 17'd0;
        end else begin
            w_matte_raw = w_psum[48:32];
        end
        w_matte = r_invert ? (ONE_Q16 - w_matte_raw) : w_matte_raw;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s10_matte <= w_matte;
            r_s10_rgba  <= r_s9_rgba;
        end
    end

    // ------------------------------------------------------------------
    // stage 11: scale rgba, output register
    // ------------------------------------------------------------------
    function automatic logic [15:0] scale_ch(input logic [15:0] c, input logic [16:0] m);
        logic [32:0] prod;
        prod = 33'(c) * 33'(m) + CH_RND;
        return prod[31:16];
    endfunction

    t_out_beat r_out;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.red_out     <= scale_ch(r_s10_rgba.r, r_s10_matte);
            r_out.green_out   <= scale_ch(r_s10_rgba.g, r_s10_matte);
            r_out.blue_out    <= scale_ch(r_s10_rgba.b, r_s10_matte);
            r_out.alpha_out   <= scale_ch(r_s10_rgba.a, r_s10_matte);
            r_out.matte_value <= r_s10_matte;
        end
    end

    // ------------------------------------------------------------------
    // valid bits of the local stages
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_s5_vld  <= 1'b0;
            r_s6_vld  <= 1'b0;
            r_s7_vld  <= 1'b0;
            r_s8_vld  <= 1'b0;
            r_s9_vld  <= 1'b0;
            r_s10_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld  <= i_in_valid;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_s4_vld  <= r_s3_vld;
            r_s5_vld  <= r_s4_vld;
            r_s6_vld  <= w_q2_vld;
            r_s7_vld  <= r_s6_vld;
            r_s8_vld  <= w_t_vld;
            r_s9_vld  <= r_s8_vld;
            r_s10_vld <= r_s9_vld;
            r_out_vld <= r_s10_vld;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

>>> hw/rtl/dgnm_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dgnm_isqrt
// pipelined integer square root, one result bit per stage, floor result
// ----------------------------------------------------------------------------
module dgnm_isqrt #(
    parameter int IN_W = 64,
    parameter int SB_W = 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire dgnm_pkg::t_pipe_ctl  i_ctl,
    input  wire logic [IN_W-1:0]      i_rad,
    input  wire logic [SB_W-1:0]      i_sb,
    output logic                      o_vld,
    output logic [IN_W/2-1:0]         o_root,
    output logic [SB_W-1:0]           o_sb
);
    import dgnm_pkg::*;

    localparam int STEPS = IN_W / 2;

    logic [STEPS-1:0] r_vld;
    logic [IN_W-1:0]  r_rem [STEPS];
    logic [IN_W-1:0]  r_res [STEPS];
    logic [SB_W-1:0]  r_sb  [STEPS];

    logic [STEPS-1:0] n_vld;
    logic [IN_W-1:0]  n_rem [STEPS];
    logic [IN_W-1:0]  n_res [STEPS];
    logic [SB_W-1:0]  n_sb  [STEPS];

    always_comb begin
        logic [IN_W-1:0] s_rem;
        logic [IN_W-1:0] s_res;
        logic [IN_W-1:0] s_bit;
        logic [IN_W-1:0] s_try;
        logic [SB_W-1:0] s_sb;
        logic            s_vld;
        for (int k = 0; k < STEPS; k++) begin
            if (k == 0) begin
                s_rem = i_rad;
                s_res = '0;
                s_sb  = i_sb;
                s_vld = i_ctl.vld;
            end else begin
                s_rem = r_rem[k-1];
                s_res = r_res[k-1];
                s_sb  = r_sb[k-1];
                s_vld = r_vld[k-1];
            end
            s_bit = IN_W'(1) << (IN_W - 2 - 2 * k);
            s_try = s_res + s_bit;
            if (s_rem >= s_try) begin
                n_rem[k] = s_rem - s_try;
                n_res[k] = (s_res >> 1) + s_bit;
            end else begin
                n_rem[k] = s_rem;
                n_res[k] = s_res >> 1;
            end
            n_sb[k]  = s_sb;
            n_vld[k] = s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.en) begin
            r_vld <= n_vld;
        end
        if (i_ctl.en) begin
            r_rem <= n_rem;
            r_res <= n_res;
            r_sb  <= n_sb;
        end
    end

    assign o_vld  = r_vld[STEPS-1];
    assign o_root = r_res[STEPS-1][IN_W/2-1:0];
    assign o_sb   = r_sb[STEPS-1];

endmodule
`default_nettype wire

>>> hw/rtl/dgnm_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dgnm_div
// pipelined restoring divider, one quotient bit per stage, floor quotient
// ----------------------------------------------------------------------------
module dgnm_div #(
    parameter int NUM_W = 63,
    parameter int DEN_W = 32,
    parameter int QUO_W = 32,
    parameter int SB_W  = 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire dgnm_pkg::t_pipe_ctl  i_ctl,
    input  wire logic [NUM_W-1:0]     i_num,
    input  wire logic [DEN_W-1:0]     i_den,
    input  wire logic [SB_W-1:0]      i_sb,
    output logic                      o_vld,
    output logic [QUO_W-1:0]          o_quo,
    output logic [SB_W-1:0]           o_sb
);
    import dgnm_pkg::*;

    localparam int REM_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [QUO_W-1:0] r_vld;
    logic [REM_W-1:0] r_rem [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];
    logic [SB_W-1:0]  r_sb  [QUO_W];

    logic [QUO_W-1:0] n_vld;
    logic [REM_W-1:0] n_rem [QUO_W];
    logic [DEN_W-1:0] n_den [QUO_W];
    logic [QUO_W-1:0] n_quo [QUO_W];
    logic [SB_W-1:0]  n_sb  [QUO_W];

    always_comb begin
        logic [REM_W-1:0] s_rem;
        logic [REM_W-1:0] s_trial;
        logic [DEN_W-1:0] s_den;
        logic [QUO_W-1:0] s_quo;
        logic [SB_W-1:0]  s_sb;
        logic             s_vld;
        for (int k = 0; k < QUO_W; k++) begin
            if (k == 0) begin
                s_rem = REM_W'(i_num);
                s_den = i_den;
                s_quo = '0;
                s_sb  = i_sb;
                s_vld = i_ctl.vld;
            end else begin
                s_rem = r_rem[k-1];
                s_den = r_den[k-1];
                s_quo = r_quo[k-1];
                s_sb  = r_sb[k-1];
                s_vld = r_vld[k-1];
            end
            s_trial = REM_W'(s_den) << (QUO_W - 1 - k);
            if (s_rem >= s_trial) begin
                n_rem[k] = s_rem - s_trial;
                n_quo[k] = s_quo | (QUO_W'(1) << (QUO_W - 1 - k));
            end else begin
                n_rem[k] = s_rem;
                n_quo[k] = s_quo;
            end
            n_den[k] = s_den;
            n_sb[k]  = s_sb;
            n_vld[k] = s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.en) begin
            r_vld <= n_vld;
        end
        if (i_ctl.en) begin
            r_rem <= n_rem;
            r_den <= n_den;
            r_quo <= n_quo;
            r_sb  <= n_sb;
        end
    end

    assign o_vld = r_vld[QUO_W-1];
    assign o_quo = r_quo[QUO_W-1];
    assign o_sb  = r_sb[QUO_W-1];

endmodule
`default_nettype wire

>>> hw/rtl/dgnm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dgnm_checker
// port-level checks of the depth gradient normal matte, bound to the top level
// ----------------------------------------------------------------------------
module dgnm_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                o_in_stall,
    input wire logic                                o_out_valid,
    input wire logic                                i_out_stall,
    input wire dgnm_pkg::t_out_beat                 o_out_data
);
    import dgnm_pkg::*;

    // a waiting output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed while stalled");

    // input is held off only behind a full, stalled output
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back-pressure");

    // nothing leaves straight after reset
    a_rst_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

    // matte stays in [0, 1]
    a_matte_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.matte_value <= ONE_Q16)
        else $error("matte above one");

    // a zero matte blanks every channel
    a_zero_matte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.matte_value == 17'd0 |->
            o_out_data.red_out == 16'd0 && o_out_data.green_out == 16'd0 &&
            o_out_data.blue_out == 16'd0 && o_out_data.alpha_out == 16'd0)
        else $error("channel non-zero under zero matte");

endmodule

bind depth_gradient_normal_matte dgnm_checker u_dgnm_checker (.*);
`default_nettype wire

>>> sim/depth_gradient_normal_matte_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_gradient_normal_matte_test
// drives deep samples through the normal matte block under random idling and
// back-pressure, predicts every output beat from a fixed-point model of the
// gradient, cosine and smoothstep, and checks each field in order
// ----------------------------------------------------------------------------
module depth_gradient_normal_matte_test;
    import dgnm_pkg::*;

    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          SETTLE_CYCLES = 40;    // direction root settles after a write
    localparam int          TAIL_CYCLES   = 130;   // pipeline latency plus margin
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;  // not a register

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_beat              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_beat             o_out_data;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    // shadow of the block's registers
    longint dir_x_q, dir_y_q, dir_z_q;
    longint tol_q, soft_q, gain_q;
    bit     invert_q;

    t_out_beat matte_queue[$];   // predicted beats, oldest first
    int        fail_count;
    int        cycle_count;
    bit        sender_idles;
    bit        receiver_idles;
    bit        hold_request;     // ask the receiver for one long hold-off

    always #6 i_clk = ~i_clk;

    depth_gradient_normal_matte i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // ------------------------------------------------------------------
    // fixed-point prediction
    // ------------------------------------------------------------------
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitpos;
        res    = 0;
        bitpos = 64'd1 << 62;
        while (bitpos > v) bitpos = bitpos >> 2;
        while (bitpos != 0) begin
            if (v >= res + bitpos) begin
                v   = v - (res + bitpos);
                res = (res >> 1) + bitpos;
            end else begin
                res = res >> 1;
            end
            bitpos = bitpos >> 2;
        end
        return res;
    endfunction

    // half central difference times gain, rounded to q16 and clipped at 2^30
    function automatic longint scaled_slope(longint hi, longint lo);
        longint          g;
        longint unsigned mag;
        longint unsigned q;
        g   = (hi - lo) * gain_q;
        mag = (g < 0) ? longint'(-g) : longint'(g);
        q   = (mag + 64'd256) >> 9;
        if (q > 64'd1073741824) q = 64'd1073741824;
        return (g < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_out_beat predict_matte(t_in_beat b);
        longint          gx, gy, num, dot, thr, lo, ramp, matte;
        longint unsigned d2, n2, nl, dl, u, q, r, ut, p;
        t_out_beat       o;
        logic [15:0]     ch[4];
        gx  = scaled_slope(longint'(b.depth_right), longint'(b.depth_left));
        gy  = scaled_slope(longint'(b.depth_above), longint'(b.depth_below));
        dot = 0;
        d2  = dir_x_q * dir_x_q + dir_y_q * dir_y_q + dir_z_q * dir_z_q;
        if (d2 != 0) begin
            num = -gx * dir_x_q - gy * dir_y_q + 65536 * dir_z_q;
            n2  = gx * gx + gy * gy + (64'd1 << 32);
            nl  = int_sqrt(n2);
            dl  = int_sqrt(d2 << 32);
            u   = (num < 0) ? longint'(-num) : longint'(num);
            q   = (u << 16) / nl;
            r   = (q << 16) / dl;
            if (r > 64'd65536) r = 64'd65536;
            dot = (num < 0) ? -longint'(r) : longint'(r);
        end
        thr = 65536 - tol_q;
        lo  = thr - soft_q;
        if (soft_q == 0) begin
            // hard step
            matte = (dot >= lo) ? 65536 : 0;
        end else begin
            if (dot <= lo)       ramp = 0;
            else if (dot >= thr) ramp = 65536;
            else                 ramp = ((dot - lo) * 65536) / soft_q;
            ut    = ramp;
            p     = ut * ut * (64'd196608 - 2 * ut);
            matte = longint'((p + (64'd1 << 31)) >> 32);
        end
        if (invert_q) matte = 65536 - matte;
        ch[0] = b.red_in;
        ch[1] = b.green_in;
        ch[2] = b.blue_in;
        ch[3] = b.alpha_in;
        for (int i = 0; i < 4; i++)
            ch[i] = 16'((longint'(ch[i]) * matte + 32768) >> 16);
        o.red_out     = ch[0];
        o.green_out   = ch[1];
        o.blue_out    = ch[2];
        o.alpha_out   = ch[3];
        o.matte_value = 17'(matte);
        return o;
    endfunction

    // ------------------------------------------------------------------
    // output side: stall generation and in-order checking
    // ------------------------------------------------------------------
    int stall_left;
    int hold_left;

    task automatic report_field(string name, longint exp_v, longint act_v);
        fail_count++;
        $display("%0t mismatch %s expected %0d actual %0d", $time, name, exp_v, act_v);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (matte_queue.size() == 0) begin
                report_field("unexpected beat, matte", -1, o_out_data.matte_value);
            end else begin
                t_out_beat e;
                e = matte_queue.pop_front();
                if (e.red_out != o_out_data.red_out)
                    report_field("red_out", e.red_out, o_out_data.red_out);
                if (e.green_out != o_out_data.green_out)
                    report_field("green_out", e.green_out, o_out_data.green_out);
                if (e.blue_out != o_out_data.blue_out)
                    report_field("blue_out", e.blue_out, o_out_data.blue_out);
                if (e.alpha_out != o_out_data.alpha_out)
                    report_field("alpha_out", e.alpha_out, o_out_data.alpha_out);
                if (e.matte_value != o_out_data.matte_value)
                    report_field("matte_value", e.matte_value, o_out_data.matte_value);
            end
        end
        // stall decision for the next cycle, one assignment per edge
        if (hold_request && hold_left == 0) begin
            hold_left    = 300;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // input side helpers
    // ------------------------------------------------------------------
    task automatic send_beat(t_in_beat b);
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        matte_queue = {matte_queue, predict_matte(b)};
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (matte_queue.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (t_cfg_idx'(idx))
            CFG_DIR_X:     dir_x_q  = longint'($signed(val[15:0]));
            CFG_DIR_Y:     dir_y_q  = longint'($signed(val[15:0]));
            CFG_DIR_Z:     dir_z_q  = longint'($signed(val[15:0]));
            CFG_TOLERANCE: tol_q    = longint'(val);
            CFG_SOFTNESS:  soft_q   = longint'(val);
            CFG_GAIN:      gain_q   = longint'(val[15:0]);
            CFG_INVERT:    invert_q = val[0];
            default:       ;  // spare index, no register behind it
        endcase
    endtask

    // all registers in turn, block must be idle; waits for the direction root
    task automatic load_setting(int dx, int dy, int dz, int tol, int falloff, int gain,
                                bit inv);
        wait_drained();
        repeat (4) @(posedge i_clk);
        write_reg(CFG_DIR_X, 17'(dx));
        write_reg(CFG_DIR_Y, 17'(dy));
        write_reg(CFG_DIR_Z, 17'(dz));
        write_reg(CFG_TOLERANCE, 17'(tol));
        write_reg(CFG_SOFTNESS, 17'(falloff));
        write_reg(CFG_GAIN, 17'(gain));
        write_reg(CFG_INVERT, 17'(inv));
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic int rand_dir();
        return $urandom_range(0, 32768) - 16384;
    endfunction

    // neighbours mostly close together so the normal sweeps the whole ramp
    function automatic t_in_beat rand_sample();
        t_in_beat b;
        int       spread;
        logic [31:0] base;
        base   = $urandom;
        spread = $urandom_range(0, 3);
        b.depth_left  = base;
        b.depth_below = base;
        case (spread)
            0: begin
                b.depth_right = $urandom;
                b.depth_above = $urandom;
            end
            1: begin
                b.depth_right = base + ($urandom_range(0, 2047) - 1024);
                b.depth_above = base + ($urandom_range(0, 2047) - 1024);
            end
            default: begin
                b.depth_right = base + ($urandom_range(0, 262143) - 131072);
                b.depth_above = base + ($urandom_range(0, 262143) - 131072);
                b.depth_below = base + ($urandom_range(0, 65535) - 32768);
            end
        endcase
        b.red_in   = 16'($urandom);
        b.green_in = 16'($urandom);
        b.blue_in  = 16'($urandom);
        b.alpha_in = ($urandom_range(0, 7) == 0) ? 16'hffff : 16'($urandom);
        return b;
    endfunction

    function automatic t_in_beat make_sample(int zl, int zr, int zb, int za, logic [15:0] c);
        t_in_beat b;
        b.depth_left  = zl;
        b.depth_right = zr;
        b.depth_below = zb;
        b.depth_above = za;
        b.red_in      = c;
        b.green_in    = ~c;
        b.blue_in     = c;
        b.alpha_in    = ~c;
        return b;
    endfunction

    task automatic send_random(int count);
        repeat (count) send_beat(rand_sample());
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        // reset registers: flat and sloped surfaces against a y target
        send_beat(make_sample(0, 0, 0, 0, 16'hffff));
        send_beat(make_sample(0, 65536, 0, -65536, 16'h0000));
        // huge gradients in both directions, saturated
        send_beat(make_sample(32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff,
                              32'sh8000_0000, 16'h1234));
        send_beat(make_sample(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000,
                              32'sh7fff_ffff, 16'hffff));
        // zero direction gives a zero cosine
        load_setting(0, 0, 0, 32768, 13107, 256, 1'b0);
        send_beat(make_sample(0, 4096, 0, 8192, 16'h8000));
        // the spare index must change nothing
        wait_drained();
        write_reg(CFG_IDX_SPARE, 17'h1ffff);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        send_beat(make_sample(0, 4096, 0, 8192, 16'h8000));
        // zero softness, a hard step, on both sides of it
        load_setting(0, 0, 16384, 16384, 0, 256, 1'b0);
        send_beat(make_sample(0, 0, 0, 0, 16'hffff));
        send_beat(make_sample(0, 65536, 0, 65536, 16'hffff));
        send_beat(make_sample(0, 131072, 0, 0, 16'hffff));
        // zero gain: normal straight up, inverted matte
        load_setting(16384, -16384, 16384, 0, 65536, 0, 1'b1);
        send_beat(make_sample(32'sh8000_0000, 32'sh7fff_ffff, 0, 12345, 16'hffff));
        // tolerance and softness beyond one: thresholds outside the cosine range
        load_setting(-16384, 16384, -16384, 131071, 131071, 65535, 1'b0);
        send_beat(make_sample(0, 1000, -1000, 0, 16'hffff));
        send_beat(make_sample(0, -1000, 1000, 0, 16'h7fff));
        load_setting(16384, 16384, 16384, 0, 1, 3, 1'b1);
        send_beat(make_sample(0, 0, 0, 0, 16'hffff));
        send_beat(make_sample(0, -70000, 0, -70000, 16'hffff));
        send_beat(make_sample(-5, 5, 5, -5, 16'h0001));
    endtask

    // a sweep of register settings, each with a batch of random samples
    task automatic test_settings_sweep();
        for (int s = 0; s < 14; s++) begin
            int tol, falloff;
            tol     = ($urandom_range(0, 9) == 0) ? $urandom_range(65537, 131071)
                                                  : $urandom_range(0, 65536);
            falloff = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 65536);
            if (s == 0) falloff = 131071;
            load_setting(rand_dir(), rand_dir(), rand_dir(), tol, falloff,
                         ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(3, 65535),
                         $urandom_range(0, 1));
            send_random(100);
        end
    endtask

    // receiver holds off while samples keep coming, so the block fills up
    task automatic test_backpressure();
        load_setting(rand_dir(), rand_dir(), 16384, 32768, 13107, 256, 1'b0);
        hold_request = 1'b1;
        send_random(200);
    endtask

    // sender pauses until the pipeline has emptied, then resumes
    task automatic test_sender_pause();
        send_random(30);
        wait_drained();
        send_random(30);
    endtask

    // back-to-back traffic with no idling on either side
    task automatic test_full_rate();
        wait_drained();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        load_setting(rand_dir(), rand_dir(), rand_dir(), 20000, 30000, 512, 1'b1);
        send_random(150);
    endtask

    initial begin
        fail_count     = 0;
        cycle_count    = 0;
        stall_left     = 0;
        hold_left      = 0;
        hold_request   = 1'b0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        dir_x_q  = longint'(RST_DIR_X);
        dir_y_q  = longint'(RST_DIR_Y);
        dir_z_q  = longint'(RST_DIR_Z);
        tol_q    = longint'(RST_TOLERANCE);
        soft_q   = longint'(RST_SOFTNESS);
        gain_q   = longint'(RST_GAIN);
        invert_q = 1'b0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_stall <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_DIR_X;
        i_cfg_wdata <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        test_directed();
        test_settings_sweep();
        test_backpressure();
        test_sender_pause();
        test_full_rate();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
